@@ rtl/fe_pkg.sv @@
package fe_pkg;

    // Fixed field widths of the external item and register formats
    localparam int ELAPSED_W = 24;
    localparam int SPAN_W    = 24;
    localparam int PEAK_W    = 16;
    localparam int OPACITY_W = 16;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_RAMP_IN  = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_RAMP_OUT = 2'd2;
    localparam logic [1:0] REG_PEAK     = 2'd3;

    // Reset value of the peak register
    localparam logic [PEAK_W-1:0] PEAK_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_IN   = 2'd1,
        PH_HOLD = 2'd2,
        PH_OUT  = 2'd3
    } t_phase;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LEFT = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_ADV  = 8'b0000_1000,
        S_NEG  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

@@ rtl/fe_if.sv @@
interface fe_in_if;
    import fe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [ELAPSED_W-1:0] elapsed;

    modport source (output valid, output mode, output elapsed, input ready);
    modport sink   (input valid, input mode, input elapsed, output ready);
endinterface

interface fe_out_if;
    import fe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPACITY_W-1:0] opacity;
    logic                 active;

    modport source (output valid, output opacity, output active, input ready);
    modport sink   (input valid, input opacity, input active, output ready);
endinterface

@@ rtl/fe_alu.sv @@
module fe_alu #(
    parameter int W = 25
) (
    input  fe_pkg::t_alu_op i_op,
    input  logic [W-1:0]    i_a,
    input  logic [W-1:0]    i_b,
    output logic [W:0]      o_res
);
    import fe_pkg::*;

    // o_res[W] is carry on add, borrow on subtract
    always_comb begin
        case (i_op)
            ALU_ADD: o_res = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: o_res = {1'b0, i_a} - {1'b0, i_b};
            default: o_res = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end
endmodule

@@ rtl/fe_regs.sv @@
module fe_regs #(
    parameter int TIME_BITS  = 24,
    parameter int LEVEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fe_pkg::ADDR_W-1:0] paddr,
    input  logic [fe_pkg::DATA_W-1:0] pwdata,
    output logic [fe_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output logic [TIME_BITS-1:0]      o_ramp_in,
    output logic [TIME_BITS-1:0]      o_hold,
    output logic [TIME_BITS-1:0]      o_ramp_out,
    output logic [LEVEL_BITS-1:0]     o_peak
);
    import fe_pkg::*;

    localparam int CW = (TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W;
    localparam int LW = (LEVEL_BITS > PEAK_W) ? LEVEL_BITS : PEAK_W;
    localparam logic [LW-1:0] PEAK_EXT = LW'(PEAK_RESET);

    logic [TIME_BITS-1:0]  r_ramp_in, r_hold, r_ramp_out;
    logic [LEVEL_BITS-1:0] r_peak;
    logic [CW-1:0]         span_wr;
    logic [LW-1:0]         peak_wr;
    logic                  wr_en;
    logic [1:0]            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    // narrower builds keep only the low bits of a written value
    assign span_wr = CW'(pwdata[SPAN_W-1:0]);
    assign peak_wr = LW'(pwdata[PEAK_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_in  <= '0;
            r_hold     <= '0;
            r_ramp_out <= '0;
            r_peak     <= PEAK_EXT[LEVEL_BITS-1:0];
        end else if (wr_en) begin
            case (reg_idx)
                REG_RAMP_IN:  r_ramp_in  <= span_wr[TIME_BITS-1:0];
                REG_HOLD:     r_hold     <= span_wr[TIME_BITS-1:0];
                REG_RAMP_OUT: r_ramp_out <= span_wr[TIME_BITS-1:0];
                REG_PEAK:     r_peak     <= peak_wr[LEVEL_BITS-1:0];
                default:      r_peak     <= r_peak;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RAMP_IN:  prdata = DATA_W'(r_ramp_in);
            REG_HOLD:     prdata = DATA_W'(r_hold);
            REG_RAMP_OUT: prdata = DATA_W'(r_ramp_out);
            REG_PEAK:     prdata = DATA_W'(r_peak);
            default:      prdata = '0;
        endcase
    end

    assign o_ramp_in  = r_ramp_in;
    assign o_hold     = r_hold;
    assign o_ramp_out = r_ramp_out;
    assign o_peak     = r_peak;
endmodule

@@ rtl/fe_seq.sv @@
module fe_seq #(
    parameter int TIME_BITS  = 24,
    parameter int LEVEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [TIME_BITS-1:0]         i_ramp_in,
    input  logic [TIME_BITS-1:0]         i_hold,
    input  logic [TIME_BITS-1:0]         i_ramp_out,
    input  logic [LEVEL_BITS-1:0]        i_peak,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic [fe_pkg::ELAPSED_W-1:0] i_elapsed,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fe_pkg::OPACITY_W-1:0] o_opacity,
    output logic                         o_active
);
    import fe_pkg::*;

    localparam int CW   = (TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W;
    localparam int AW   = CW + 1;
    localparam int PW   = TIME_BITS + LEVEL_BITS;
    localparam int CNTW = $clog2(LEVEL_BITS);
    localparam int LW   = (LEVEL_BITS > OPACITY_W) ? LEVEL_BITS : OPACITY_W;
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(LEVEL_BITS - 1);

    t_state                r_state, n_state;
    t_phase                r_phase, n_phase;
    logic [TIME_BITS-1:0]  r_timer, n_timer;
    logic [LEVEL_BITS-1:0] r_level, n_level;
    logic [ELAPSED_W-1:0]  r_rem, n_rem;
    logic [TIME_BITS-1:0]  r_left, n_left;
    logic [TIME_BITS-1:0]  r_mul, n_mul;
    logic [PW-1:0]         r_acc, n_acc;
    logic [CNTW-1:0]       r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [OPACITY_W-1:0]  r_opacity, n_opacity;
    logic                  r_active, n_active;

    t_alu_op               alu_op;
    logic [AW-1:0]         alu_a, alu_b;
    logic [AW:0]           alu_res;
    logic [TIME_BITS-1:0]  span;
    logic [LW-1:0]         level_ext;
    logic [PW-1:0]         acc_init;

    fe_alu #(.W(AW)) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    always_comb begin
        case (r_phase)
            PH_IN:   span = i_ramp_in;
            PH_HOLD: span = i_hold;
            default: span = i_ramp_out;
        endcase
    end

    assign acc_init  = {{TIME_BITS{1'b0}}, i_peak};
    assign level_ext = LW'(r_level);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_level     = r_level;
        n_rem       = r_rem;
        n_left      = r_left;
        n_mul       = r_mul;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_opacity   = r_opacity;
        n_active    = r_active;
        alu_op      = ALU_SUB;
        alu_a       = '0;
        alu_b       = '0;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_mode) begin
                        n_timer = '0;
                        if (i_ramp_in != '0) begin
                            n_phase = PH_IN;
                            n_level = '0;
                        end else begin
                            n_phase = PH_HOLD;
                            n_level = i_peak;
                        end
                        n_state = S_DONE;
                    end else if (r_phase != PH_IDLE && i_elapsed != '0) begin
                        n_rem   = i_elapsed;
                        n_state = S_LEFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LEFT: begin
                // ticks left in phase, floored at zero
                alu_a  = AW'(span);
                alu_b  = AW'(r_timer);
                n_left = alu_res[AW] ? '0 : alu_res[TIME_BITS-1:0];
                if (r_phase == PH_HOLD) begin
                    n_level = i_peak;
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                alu_a = AW'(r_rem);
                alu_b = AW'(r_left);
                if (span != '0 && alu_res[AW]) begin
                    n_state = S_ADV;
                end else begin
                    n_rem   = alu_res[ELAPSED_W-1:0];
                    n_timer = '0;
                    case (r_phase)
                        PH_IN: begin
                            n_level = i_peak;
                            n_phase = PH_HOLD;
                        end
                        PH_HOLD: n_phase = PH_OUT;
                        default: begin
                            n_level = '0;
                            n_phase = PH_IDLE;
                        end
                    endcase
                    n_state = (n_rem != '0 && n_phase != PH_IDLE) ? S_LEFT : S_DONE;
                end
            end
            S_ADV: begin
                alu_op  = ALU_ADD;
                alu_a   = AW'(r_timer);
                alu_b   = AW'(r_rem);
                n_timer = alu_res[TIME_BITS-1:0];
                n_rem   = '0;
                case (r_phase)
                    PH_IN: begin
                        n_mul   = alu_res[TIME_BITS-1:0];
                        n_acc   = acc_init;
                        n_cnt   = '0;
                        n_state = S_MUL;
                    end
                    PH_OUT:  n_state = S_NEG;
                    default: n_state = S_DONE;
                endcase
            end
            S_NEG: begin
                alu_a   = AW'(span);
                alu_b   = AW'(r_timer);
                n_mul   = alu_res[TIME_BITS-1:0];
                n_acc   = acc_init;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                // shift-add, multiplier bits leave from the bottom of r_acc
                alu_op = ALU_ADD;
                alu_a  = AW'(r_acc[PW-1:LEVEL_BITS]);
                alu_b  = r_acc[0] ? AW'(r_mul) : '0;
                n_acc  = {alu_res[TIME_BITS:0], r_acc[LEVEL_BITS-1:1]};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring divide; the top TIME_BITS bits hold the partial remainder
                alu_a = AW'({r_acc[PW-1:LEVEL_BITS], r_acc[LEVEL_BITS-1]});
                alu_b = AW'(span);
                if (!alu_res[AW]) begin
                    n_acc = {alu_res[TIME_BITS-1:0], r_acc[LEVEL_BITS-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[PW-2:LEVEL_BITS-1], r_acc[LEVEL_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_level = n_acc[LEVEL_BITS-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_opacity   = level_ext[OPACITY_W-1:0];
                    n_active    = (r_phase != PH_IDLE);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_level     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_level     <= n_level;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_left    <= n_left;
        r_mul     <= n_mul;
        r_acc     <= n_acc;
        r_opacity <= n_opacity;
        r_active  <= n_active;
    end

    assign o_out_valid = r_out_valid;
    assign o_opacity   = r_opacity;
    assign o_active    = r_active;
endmodule

@@ rtl/fade_envelope_generator.sv @@
// Fade envelope generator: produces an opacity envelope that runs idle ->
// ramp in -> hold at peak -> ramp out -> idle. A start transfer (mode 1)
// re-arms the envelope; an advance transfer (mode 0) spends its elapsed ticks
// across phase boundaries, leftover ticks spilling into the next phase and
// zero-length phases passing at once. Every input transfer yields exactly one
// output transfer carrying the opacity and whether the envelope is active.
// Ramps are linear with truncation: peak*timer/span in, peak*(span-timer)/span
// out. Items are handled one at a time by a small sequencer around one shared
// add/subtract unit. A start, or an advance that changes nothing, goes from
// idle straight to the posting state. An advance passes through a ticks-left
// state and a compare state per phase (at most 3 passes) and, when it stops
// inside a phase, updates the timer; a ramp out then forms the multiplier
// operand, and a ramp runs a shift-add multiply and a restoring divide,
// LEVEL_BITS steps each, before the result is posted. The result sits in an
// output register; the next input is taken once the sequencer is back in
// idle, even while that result waits for its sink. Registers (APB, byte
// address 4*i): 0 ramp_in_ticks, 1 hold_ticks, 2 ramp_out_ticks, 3 peak_level
// (reset 65535). The user must write them only during idle; the block does
// not enforce it. New values act on the next item and the current level is
// not rescaled.
module fade_envelope_generator #(
    parameter int TIME_BITS  = 24,
    parameter int LEVEL_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fe_in_if.sink                     i_item,
    fe_out_if.source                  o_result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fe_pkg::ADDR_W-1:0] paddr,
    input  logic [fe_pkg::DATA_W-1:0] pwdata,
    output logic [fe_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import fe_pkg::*;

    logic [TIME_BITS-1:0]  ramp_in, hold, ramp_out;
    logic [LEVEL_BITS-1:0] peak;

    // configuration registers
    fe_regs #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_ramp_in  (ramp_in),
        .o_hold     (hold),
        .o_ramp_out (ramp_out),
        .o_peak     (peak)
    );

    // envelope state, sequencer and shared arithmetic
    fe_seq #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ramp_in   (ramp_in),
        .i_hold      (hold),
        .i_ramp_out  (ramp_out),
        .i_peak      (peak),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_mode      (i_item.mode),
        .i_elapsed   (i_item.elapsed),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_opacity   (o_result.opacity),
        .o_active    (o_result.active)
    );
endmodule

@@ tb/fade_envelope_generator_test.sv @@
module fade_envelope_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fe_pkg::*;

    // Input mode codes
    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_START   = 1'b1;

    localparam int MAX_WAIT        = 13;   // per-transfer idle draw, both sides
    localparam int HOLD_OFF_CYCLES = 400;  // long sink stall, fills the block
    localparam int DRAIN_CYCLES    = 64;   // longer than the worst-case item latency
    localparam int RANDOM_PHASES   = 40;   // x ~27 items each
    localparam int PRESSURE_PHASE  = 3;
    localparam int PAUSE_PHASE     = 6;
    localparam int DIRECTED_ROWS   = 36;

    localparam logic [SPAN_W-1:0]    SPAN_MAX = '1;
    localparam logic [OPACITY_W-1:0] FULL     = '1;

    // One opacity/active pair as it leaves the block
    typedef struct packed {
        logic [OPACITY_W-1:0] opacity;
        logic                 active;
    } t_envelope;

    // Directed table: register writes, starts and advances.
    // For ROW_WRITE, value is the register data; for ROW_ADVANCE it is elapsed.
    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_START,
        ROW_ADVANCE
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [1:0]           reg_idx;
        logic [DATA_W-1:0]    value;
        logic                 checked;   // typed-in result below is used
        logic [OPACITY_W-1:0] opacity;
        logic                 active;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    fe_in_if  item_bus ();
    fe_out_if result_bus ();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    fade_envelope_generator u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Sideband riding along with each offered item: a typed-in expectation
    logic                 tag_checked;
    logic [OPACITY_W-1:0] tag_opacity;
    logic                 tag_active;

    // Idle knobs shared between the stimulus and the sink
    int   src_max  = MAX_WAIT;
    int   sink_max = MAX_WAIT;
    logic hold_req = 1'b0;

    t_envelope envelope_q[$];
    int        mismatch_count = 0;

    // Predictor copy of registers and envelope state
    logic [SPAN_W-1:0]    cfg_ramp_in  = '0;
    logic [SPAN_W-1:0]    cfg_hold     = '0;
    logic [SPAN_W-1:0]    cfg_ramp_out = '0;
    logic [PEAK_W-1:0]    cfg_peak     = PEAK_RESET;
    t_phase               env_phase    = PH_IDLE;
    logic [SPAN_W-1:0]    env_timer    = '0;
    logic [OPACITY_W-1:0] env_level    = '0;

    // Directed rows. Typed-in results only where obvious; rest predicted.
    t_stim_row directed [DIRECTED_ROWS] = '{
        // reset values: spans 0, peak full
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd5,         1'b1, 16'd0, 1'b0}, // idle advance
        '{ROW_START,   REG_RAMP_IN,  32'd0,         1'b1, FULL,  1'b1}, // instant ramp in
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd0,         1'b1, FULL,  1'b1}, // zero elapsed
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd1,         1'b1, 16'd0, 1'b0}, // zero hold+out
        '{ROW_WRITE,   REG_RAMP_IN,  32'd100,       1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_HOLD,     32'd50,        1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_RAMP_OUT, 32'd200,       1'b0, 16'd0, 1'b0},
        '{ROW_START,   REG_RAMP_IN,  32'd0,         1'b1, 16'd0, 1'b1},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd25,        1'b0, 16'd0, 1'b0},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd75,        1'b1, FULL,  1'b1}, // exact end of ramp in
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd50,        1'b1, FULL,  1'b1}, // exact end of hold
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd100,       1'b0, 16'd0, 1'b0},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'h00FF_FFFF, 1'b1, 16'd0, 1'b0},
        '{ROW_START,   REG_RAMP_IN,  32'd0,         1'b1, 16'd0, 1'b1},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'h00FF_FFFF, 1'b1, 16'd0, 1'b0}, // spill all phases
        '{ROW_WRITE,   REG_RAMP_IN,  32'h00FF_FFFF, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_HOLD,     32'd0,         1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_RAMP_OUT, 32'h00FF_FFFF, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_PEAK,     32'd0,         1'b0, 16'd0, 1'b0},
        '{ROW_START,   REG_RAMP_IN,  32'd0,         1'b1, 16'd0, 1'b1},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'h00FF_FFFE, 1'b1, 16'd0, 1'b1}, // zero peak
        '{ROW_WRITE,   REG_PEAK,     32'h0000_FFFF, 1'b0, 16'd0, 1'b0}, // mid-ramp change
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd1,         1'b1, FULL,  1'b1}, // stops in zero hold
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd1,         1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_RAMP_OUT, 32'd1,         1'b0, 16'd0, 1'b0},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd3,         1'b1, 16'd0, 1'b0}, // timer at shortened span
        '{ROW_WRITE,   REG_RAMP_IN,  32'd1,         1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_HOLD,     32'h00FF_FFFF, 1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_RAMP_OUT, 32'd0,         1'b0, 16'd0, 1'b0},
        '{ROW_WRITE,   REG_PEAK,     32'd12345,     1'b0, 16'd0, 1'b0},
        '{ROW_START,   REG_RAMP_IN,  32'd0,         1'b1, 16'd0, 1'b1},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd1,         1'b1, 16'd12345, 1'b1},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'h00FF_FFFF, 1'b1, 16'd12345, 1'b1},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'd1,         1'b1, 16'd0, 1'b0}, // instant ramp out
        '{ROW_START,   REG_RAMP_IN,  32'd0,         1'b1, 16'd0, 1'b1},
        '{ROW_ADVANCE, REG_RAMP_IN,  32'h0080_0000, 1'b0, 16'd0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Envelope predictor: one call per accepted input item
    // ------------------------------------------------------------------
    function automatic t_envelope step_envelope(input logic mode,
                                                input logic [ELAPSED_W-1:0] elapsed);
        logic [63:0] remaining;
        logic [63:0] span;
        logic [63:0] left;
        logic [63:0] timer;
        logic [63:0] peak;
        t_envelope   res;
        peak      = 64'(cfg_peak);
        timer     = 64'(env_timer);
        remaining = 64'(elapsed);
        if (mode == MODE_START) begin
            env_timer = '0;
            env_level = '0;
            if (cfg_ramp_in != '0) begin
                env_phase = PH_IN;
            end else begin
                env_level = cfg_peak;
                env_phase = PH_HOLD;
            end
        end else begin
            // each round eats the rest of the ticks or closes one phase
            for (int round = 0; round < 4; round++) begin
                if (remaining != 0 && env_phase != PH_IDLE) begin
                    case (env_phase)
                        PH_IN: begin
                            span = 64'(cfg_ramp_in);
                        end
                        PH_HOLD: begin
                            span      = 64'(cfg_hold);
                            env_level = cfg_peak;
                        end
                        default: begin
                            span = 64'(cfg_ramp_out);
                        end
                    endcase
                    left = (timer < span) ? span - timer : 64'd0;
                    if (span != 0 && remaining < left) begin
                        timer     = timer + remaining;
                        remaining = 0;
                        if (env_phase == PH_IN) begin
                            env_level = OPACITY_W'((peak * timer) / span);
                        end else if (env_phase == PH_OUT) begin
                            env_level = OPACITY_W'((peak * (span - timer)) / span);
                        end
                    end else begin
                        remaining = remaining - left;
                        timer     = 0;
                        case (env_phase)
                            PH_IN: begin
                                env_level = cfg_peak;
                                env_phase = PH_HOLD;
                            end
                            PH_HOLD: begin
                                env_phase = PH_OUT;
                            end
                            default: begin
                                env_level = '0;
                                env_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            env_timer = timer[SPAN_W-1:0];
        end
        res.opacity = env_level;
        res.active  = (env_phase != PH_IDLE);
        return res;
    endfunction

    // Span draw: mostly short so envelopes run through all phases
    function automatic logic [DATA_W-1:0] random_span();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return DATA_W'(SPAN_MAX);
        if (sel < 4)  return DATA_W'($urandom & 32'h00FF_FFFF);
        return DATA_W'($urandom_range(1, 40));
    endfunction

    function automatic logic [ELAPSED_W-1:0] random_elapsed();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (sel < 4)  return ELAPSED_W'($urandom);
        return ELAPSED_W'($urandom_range(1, 24));
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // single reset at start, never again
    initial begin
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // generous limit on the whole run
    initial begin
        #2_000_000;
        $display("fade_envelope_generator_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: mirror register writes, predict on input transfer,
    // check on output transfer. Samples pre-edge values only.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_envelope want;
        t_envelope got;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_RAMP_IN:  cfg_ramp_in  = pwdata[SPAN_W-1:0];
                    REG_HOLD:     cfg_hold     = pwdata[SPAN_W-1:0];
                    REG_RAMP_OUT: cfg_ramp_out = pwdata[SPAN_W-1:0];
                    default:      cfg_peak     = pwdata[PEAK_W-1:0];
                endcase
            end
            if (item_bus.valid && item_bus.ready) begin
                want = step_envelope(item_bus.mode, item_bus.elapsed);
                // typed-in row value replaces the prediction; state still advances
                if (tag_checked) begin
                    want.opacity = tag_opacity;
                    want.active  = tag_active;
                end
                envelope_q.push_back(want);
            end
            if (result_bus.valid && result_bus.ready) begin
                got.opacity = result_bus.opacity;
                got.active  = result_bus.active;
                if (envelope_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: opacity %0d active %0d",
                                 got.opacity, got.active);
                    end
                end else begin
                    want = envelope_q.pop_front();
                    if (got.opacity !== want.opacity || got.active !== want.active) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: opacity exp %0d got %0d, active exp %0d got %0d",
                                     want.opacity, got.opacity, want.active, got.active);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random wait per transfer, plus one long hold-off
    // on request so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int wait_n;
        result_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                result_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            wait_n = $urandom_range(0, sink_max);
            if (wait_n != 0) begin
                result_bus.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_bus.valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Offer one item after a random gap; returns at the transfer edge
    // with valid still high, so back-to-back items need no re-raise.
    task automatic send_item(input logic                 mode,
                             input logic [ELAPSED_W-1:0] elapsed,
                             input logic                 checked,
                             input logic [OPACITY_W-1:0] opacity,
                             input logic                 active);
        int gap;
        gap = $urandom_range(0, src_max);
        if (gap != 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.mode    <= mode;
        item_bus.elapsed <= elapsed;
        tag_checked      <= checked;
        tag_opacity      <= opacity;
        tag_active       <= active;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every result is back; the block's
    // sequencer is idle then, since each item yields one result. The
    // first edge lets the monitor log a transfer taken at the call edge.
    task automatic settle();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (envelope_q.size() != 0) @(posedge i_clk);
    endtask

    // Setup + access; leaves psel high so a following write chains cleanly
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int   n_items;
        logic start_now;
        logic noisy;
        item_bus.valid   <= 1'b0;
        item_bus.mode    <= MODE_ADVANCE;
        item_bus.elapsed <= '0;
        tag_checked      <= 1'b0;
        tag_opacity      <= '0;
        tag_active       <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        // directed table: extremes, exact boundaries, zero spans,
        // timer at the end of a shortened span, mid-ramp peak change
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].kind == ROW_WRITE) begin
                // chained writes follow each other with nothing in flight
                if (i == 0 || directed[i - 1].kind != ROW_WRITE) begin
                    settle();
                end
                write_reg(directed[i].reg_idx, directed[i].value);
                if (i == DIRECTED_ROWS - 1 || directed[i + 1].kind != ROW_WRITE) begin
                    bus_release();
                end
            end else begin
                send_item((directed[i].kind == ROW_START) ? MODE_START : MODE_ADVANCE,
                          directed[i].value[ELAPSED_W-1:0], directed[i].checked,
                          directed[i].opacity, directed[i].active);
            end
        end

        // random phases: new registers each phase, envelope state carried
        // over when a phase does not open with a start
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            write_reg(REG_RAMP_IN, random_span());
            write_reg(REG_HOLD, random_span());
            write_reg(REG_RAMP_OUT, random_span());
            write_reg(REG_PEAK, (($urandom_range(0, 3) == 0) ? DATA_W'(FULL) :
                                 DATA_W'($urandom_range(0, 65535))));
            bus_release();

            // some phases run without idling on one or both sides
            src_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
            sink_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_WAIT;
            if (ph == PRESSURE_PHASE) begin
                src_max  = 0;
                hold_req = 1'b1;
            end
            noisy   = ($urandom_range(0, 4) == 0);
            n_items = $urandom_range(20, 35);

            for (int k = 0; k < n_items; k++) begin
                // one sender pause until the pipeline is empty
                if (ph == PAUSE_PHASE && k == n_items / 2) begin
                    settle();
                end
                if (k == 0) begin
                    start_now = ($urandom_range(0, 3) != 0);
                end else begin
                    start_now = ($urandom_range(0, noisy ? 1 : 11) == 0);
                end
                send_item(start_now ? MODE_START : MODE_ADVANCE, random_elapsed(),
                          1'b0, '0, 1'b0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatch_count += envelope_q.size();

        if (mismatch_count == 0) begin
            $display("fade_envelope_generator_test OK");
        end else begin
            $display("fade_envelope_generator_test NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/fe_pkg.sv
rtl/fe_if.sv
rtl/fe_alu.sv
rtl/fe_regs.sv
rtl/fe_seq.sv
rtl/fade_envelope_generator.sv
tb/fade_envelope_generator_test.sv
